@@ sv/ttsw_pkg.sv @@
// Shared constants, codes and types of the text terminal screen writer.
`default_nettype none

package ttsw_pkg;

    // Screen store geometry and attribute width.
    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 64;
    localparam int ATTR_BITS = 32;

    // Field widths of the channels.
    localparam int GLYPH_W  = 21;
    localparam int ATTR_W   = 32;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 7;
    localparam int SCROLL_W = 2;

    // Configuration register widths and port.
    localparam int COLS_REG_W = 8;
    localparam int ROWS_REG_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd25;

    // Internal cursor and store address widths.
    localparam int CCOL_W = $clog2(MAX_COLS);
    localparam int CROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = CROW_W + CCOL_W;
    localparam int CELL_W = GLYPH_W + ATTR_BITS;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Command queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMNS = 2'd0,
        REG_ROWS    = 2'd1,
        REG_ATTR    = 2'd2
    } cfg_reg_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [GLYPH_W-1:0] CHAR_BS        = 21'h08;
    localparam logic [GLYPH_W-1:0] CHAR_LF        = 21'h0A;
    localparam logic [GLYPH_W-1:0] CHAR_CR        = 21'h0D;
    localparam logic [GLYPH_W-1:0] CHAR_ESC       = 21'h1B;
    localparam logic [GLYPH_W-1:0] CHAR_CSI       = 21'h9B;
    localparam logic [GLYPH_W-1:0] CHAR_LBRACKET  = 21'h5B;
    localparam logic [GLYPH_W-1:0] CHAR_SGR_END   = 21'h6D;
    localparam logic [GLYPH_W-1:0] CHAR_PRINT_MIN = 21'h08;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_NOP,
        CMD_LF,
        CMD_CR,
        CMD_BS,
        CMD_PUT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [GLYPH_W-1:0] code_point;
        logic               wide;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC,
        BK_PUT,
        BK_SCROLL,
        BK_READ,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

@@ sv/ttsw_ifs.sv @@
// Request and response channel interfaces of the screen writer.
`default_nettype none

interface ttsw_req_if import ttsw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [GLYPH_W-1:0] code_point;
    logic               is_wide;
    logic [ROW_W-1:0]   read_row;
    logic [COL_W-1:0]   read_col;

    modport source (output valid, operation, code_point, is_wide, read_row, read_col,
                    input ready);
    modport sink (input valid, operation, code_point, is_wide, read_row, read_col,
                  output ready);
endinterface

interface ttsw_rsp_if import ttsw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [GLYPH_W-1:0]  cell_glyph;
    logic [ATTR_W-1:0]   cell_attr;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_col;
    logic [SCROLL_W-1:0] scroll_count;

    modport source (output valid, cell_glyph, cell_attr, cursor_row, cursor_col,
                    scroll_count, input ready);
    modport sink (input valid, cell_glyph, cell_attr, cursor_row, cursor_col,
                  scroll_count, output ready);
endinterface

`default_nettype wire

@@ sv/ttsw_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module ttsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

@@ sv/ttsw_front.sv @@
// Front end: accepts items, runs the escape filter and classifies them into commands.
`default_nettype none

module ttsw_front import ttsw_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic clearing,
    ttsw_req_if.sink  req,
    input  q_status_t q_status,
    output logic      push,
    output cmd_t      push_cmd
);

    logic escape_seen_reg, escape_seen_next;
    logic in_csi_reg, in_csi_next;
    logic esc_class, csi_class;
    logic accept;

    assign req.ready = !q_status.full && !clearing;
    assign accept    = req.valid && req.ready;
    assign push      = accept;

    // Line control codes bypass the escape filter, which only sees codes from 8 up.
    always_comb
    begin
        push_cmd.kind       = CMD_NOP;
        push_cmd.code_point = req.code_point;
        push_cmd.wide       = req.is_wide;
        push_cmd.row        = req.read_row;
        push_cmd.col        = req.read_col;
        esc_class           = escape_seen_reg;
        csi_class           = in_csi_reg;
        if (req.operation == OP_READ)
        begin
            push_cmd.kind = CMD_READ;
        end
        else if (req.code_point == CHAR_LF)
        begin
            push_cmd.kind = CMD_LF;
        end
        else if (req.code_point == CHAR_CR)
        begin
            push_cmd.kind = CMD_CR;
        end
        else if (req.code_point == CHAR_BS)
        begin
            push_cmd.kind = CMD_BS;
        end
        else if (req.code_point < CHAR_PRINT_MIN)
        begin
            push_cmd.kind = CMD_NOP;
        end
        else if (escape_seen_reg && req.code_point == CHAR_LBRACKET)
        begin
            csi_class = 1'b1;
            esc_class = 1'b0;
        end
        else if (in_csi_reg)
        begin
            if (req.code_point == CHAR_SGR_END)
            begin
                csi_class = 1'b0;
            end
        end
        else if (req.code_point == CHAR_ESC)
        begin
            esc_class = 1'b1;
        end
        else if (req.code_point == CHAR_CSI)
        begin
            csi_class = 1'b1;
        end
        else
        begin
            push_cmd.kind = CMD_PUT;
        end
    end

    assign escape_seen_next = accept ? esc_class : escape_seen_reg;
    assign in_csi_next      = accept ? csi_class : in_csi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_seen_reg <= 1'b0;
            in_csi_reg      <= 1'b0;
        end
        else
        begin
            escape_seen_reg <= escape_seen_next;
            in_csi_reg      <= in_csi_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ttsw_cmd_fifo.sv @@
// Short command queue between the front end and the screen engine.
`default_nettype none

module ttsw_cmd_fifo import ttsw_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output q_status_t q_status
);

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_cmd        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ttsw_back.sv @@
// Screen engine: cursor, scrolling, the cell store and the result register.
`default_nettype none

module ttsw_back import ttsw_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  q_status_t                  q_status,
    input  cmd_t                       pop_cmd,
    output logic                       pop,
    output logic                       clearing,
    ttsw_rsp_if.source                 rsp
);

    back_state_t state_reg, state_next;

    logic [COLS_REG_W-1:0] cols_reg, cols_next;
    logic [ROWS_REG_W-1:0] rows_reg, rows_next;
    logic [CFG_DATA_W-1:0] attr_cfg_reg, attr_cfg_next;

    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [CROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [CCOL_W-1:0]    cur_col_reg, cur_col_next;
    logic [CROW_W-1:0]    top_reg, top_next;
    logic [CROW_W-1:0]    clr_row_reg, clr_row_next;
    logic [CCOL_W-1:0]    clr_col_reg, clr_col_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [1:0]           puts_left_reg, puts_left_next;
    logic [SCROLL_W-1:0]  scroll_cnt_reg, scroll_cnt_next;
    logic [GLYPH_W-1:0]   res_glyph_reg, res_glyph_next;
    logic [ATTR_BITS-1:0] res_attr_reg, res_attr_next;

    logic                 out_valid_reg, out_valid_next;
    logic [GLYPH_W-1:0]   out_glyph_reg, out_glyph_next;
    logic [ATTR_W-1:0]    out_attr_reg, out_attr_next;
    logic [ROW_W-1:0]     out_row_reg, out_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [SCROLL_W-1:0]  out_scroll_reg, out_scroll_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [CELL_W-1:0]     ram_wdata;
    logic [CELL_W-1:0]     ram_rdata;

    logic [COLS_REG_W-1:0] nc;
    logic [ROWS_REG_W-1:0] nr;
    logic [ROWS_REG_W-1:0] top_w, row_w;
    logic [COLS_REG_W-1:0] col_w;
    logic                  norm_ok;
    logic                  last_row;
    logic                  top_last;
    logic                  col_wrap;
    logic                  pre_wrap;
    logic                  read_hit;
    logic                  bs_home;
    logic [CROW_W-1:0]     bs_row;
    logic [CCOL_W-1:0]     bs_col;
    logic                  out_free;
    logic                  out_load;
    logic                  scroll_setup;

    // Physical cell address: the store is a ring of rows starting at the top offset.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [CROW_W-1:0]     row,
        input logic [CCOL_W-1:0]     col,
        input logic [CROW_W-1:0]     top,
        input logic [ROWS_REG_W-1:0] nrows
    );
        logic [ROWS_REG_W:0] sum;
        logic [ROWS_REG_W:0] red;
        sum = {1'b0, ROWS_REG_W'(row)} + {1'b0, ROWS_REG_W'(top)};
        if (sum >= {1'b0, nrows})
        begin
            red = sum - {1'b0, nrows};
        end
        else
        begin
            red = sum;
        end
        return {CROW_W'(red), col};
    endfunction

    ttsw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Effective screen size after clamping the registers.
    always_comb
    begin
        if (cols_reg < 2)
        begin
            nc = COLS_REG_W'(2);
        end
        else if (cols_reg > MAX_COLS)
        begin
            nc = COLS_REG_W'(MAX_COLS);
        end
        else
        begin
            nc = cols_reg;
        end
        if (rows_reg < 1)
        begin
            nr = ROWS_REG_W'(1);
        end
        else if (rows_reg > MAX_ROWS)
        begin
            nr = ROWS_REG_W'(MAX_ROWS);
        end
        else
        begin
            nr = rows_reg;
        end
    end

    assign top_w    = ROWS_REG_W'(top_reg);
    assign row_w    = ROWS_REG_W'(cur_row_reg);
    assign col_w    = COLS_REG_W'(cur_col_reg);
    assign norm_ok  = (top_w < nr) && (row_w < nr) && (col_w < nc);
    assign last_row = ({1'b0, row_w} + 1'b1) >= {1'b0, nr};
    assign top_last = ({1'b0, top_w} + 1'b1) >= {1'b0, nr};
    assign col_wrap = ({1'b0, col_w} + 1'b1) >= {1'b0, nc};
    assign pre_wrap = cmd_reg.wide && col_wrap;
    assign read_hit = (ROWS_REG_W'(cmd_reg.row) < nr) && (COLS_REG_W'(cmd_reg.col) < nc);
    assign bs_home  = (cur_row_reg == '0) && (cur_col_reg == '0);
    assign bs_row   = (cur_col_reg == '0) ? cur_row_reg - 1'b1 : cur_row_reg;
    assign bs_col   = (cur_col_reg == '0) ? CCOL_W'(nc - COLS_REG_W'(1))
                                          : cur_col_reg - 1'b1;
    assign out_free = !out_valid_reg || rsp.ready;
    assign clearing = (state_reg == BK_CLEAR);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_status.empty && norm_ok)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                case (cmd_reg.kind)
                    CMD_READ: state_next = read_hit ? BK_READ : BK_DONE;
                    CMD_LF:   state_next = last_row ? BK_SCROLL : BK_DONE;
                    CMD_PUT:  state_next = (pre_wrap && last_row) ? BK_SCROLL : BK_PUT;
                    default:  state_next = BK_DONE;
                endcase
            end
            BK_PUT:
            begin
                if (col_wrap && last_row)
                begin
                    state_next = BK_SCROLL;
                end
                else if (puts_left_reg > 2'd1)
                begin
                    state_next = BK_PUT;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end
            BK_SCROLL:
            begin
                if (clr_col_reg == CCOL_W'(MAX_COLS - 1))
                begin
                    state_next = (puts_left_reg != '0) ? BK_PUT : BK_DONE;
                end
            end
            BK_READ:
            begin
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = (!q_status.empty && norm_ok) ? BK_EXEC : BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Store port, queue pop and result load.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = cell_addr(cur_row_reg, cur_col_reg, top_reg, nr);
        ram_wdata = '0;
        pop       = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_addr_reg;
            end
            BK_IDLE:
            begin
                pop = !q_status.empty && norm_ok;
            end
            BK_EXEC:
            begin
                if (cmd_reg.kind == CMD_READ)
                begin
                    ram_addr = cell_addr(CROW_W'(cmd_reg.row), CCOL_W'(cmd_reg.col),
                                         top_reg, nr);
                end
                else if (cmd_reg.kind == CMD_BS && !bs_home)
                begin
                    ram_we   = 1'b1;
                    ram_addr = cell_addr(bs_row, bs_col, top_reg, nr);
                end
            end
            BK_PUT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {cmd_reg.code_point, ATTR_BITS'(attr_cfg_reg)};
            end
            BK_SCROLL:
            begin
                ram_we   = 1'b1;
                ram_addr = {clr_row_reg, clr_col_reg};
            end
            BK_DONE:
            begin
                out_load = out_free;
                pop      = out_free && !q_status.empty && norm_ok;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Cursor, scroll and result datapath.
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        top_next        = top_reg;
        clr_row_next    = clr_row_reg;
        clr_col_next    = clr_col_reg;
        cmd_next        = cmd_reg;
        puts_left_next  = puts_left_reg;
        scroll_cnt_next = scroll_cnt_reg;
        res_glyph_next  = res_glyph_reg;
        res_attr_next   = res_attr_reg;
        scroll_setup    = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            BK_IDLE:
            begin
                // After a size change the cursor is clamped and the top offset
                // is reduced by one subtraction per cycle.
                if (!norm_ok)
                begin
                    if (top_w >= nr)
                    begin
                        top_next = CROW_W'(top_w - nr);
                    end
                    if (row_w >= nr)
                    begin
                        cur_row_next = CROW_W'(nr - ROWS_REG_W'(1));
                    end
                    if (col_w >= nc)
                    begin
                        cur_col_next = CCOL_W'(nc - COLS_REG_W'(1));
                    end
                end
            end
            BK_EXEC:
            begin
                case (cmd_reg.kind)
                    CMD_LF:
                    begin
                        cur_col_next = '0;
                        if (last_row)
                        begin
                            scroll_setup = 1'b1;
                        end
                        else
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end
                    CMD_CR:
                    begin
                        cur_col_next = '0;
                    end
                    CMD_BS:
                    begin
                        if (!bs_home)
                        begin
                            cur_row_next = bs_row;
                            cur_col_next = bs_col;
                        end
                    end
                    CMD_PUT:
                    begin
                        puts_left_next = cmd_reg.wide ? 2'd2 : 2'd1;
                        if (pre_wrap)
                        begin
                            cur_col_next = '0;
                            if (last_row)
                            begin
                                scroll_setup = 1'b1;
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        cur_col_next = cur_col_reg;
                    end
                endcase
            end
            BK_PUT:
            begin
                puts_left_next = puts_left_reg - 1'b1;
                if (col_wrap)
                begin
                    cur_col_next = '0;
                    if (last_row)
                    begin
                        scroll_setup = 1'b1;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
            end
            BK_SCROLL:
            begin
                clr_col_next = clr_col_reg + 1'b1;
            end
            BK_READ:
            begin
                res_glyph_next = ram_rdata[CELL_W-1 -: GLYPH_W];
                res_attr_next  = ram_rdata[ATTR_BITS-1:0];
            end
            default:
            begin
                res_glyph_next = res_glyph_reg;
            end
        endcase

        // The line leaving the top becomes the new, blank bottom line.
        if (scroll_setup)
        begin
            top_next        = top_last ? '0 : top_reg + 1'b1;
            clr_row_next    = top_reg;
            clr_col_next    = '0;
            scroll_cnt_next = scroll_cnt_reg + 1'b1;
        end

        if (pop)
        begin
            cmd_next        = pop_cmd;
            scroll_cnt_next = '0;
            res_glyph_next  = '0;
            res_attr_next   = '0;
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_glyph_next  = out_glyph_reg;
        out_attr_next   = out_attr_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_scroll_next = out_scroll_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_glyph_next  = res_glyph_reg;
            out_attr_next   = ATTR_W'(res_attr_reg);
            out_row_next    = ROW_W'(cur_row_reg);
            out_col_next    = COL_W'(cur_col_reg);
            out_scroll_next = scroll_cnt_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration registers.
    always_comb
    begin
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        attr_cfg_next = attr_cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMNS: cols_next     = COLS_REG_W'(cfg_data);
                REG_ROWS:    rows_next     = ROWS_REG_W'(cfg_data);
                REG_ATTR:    attr_cfg_next = cfg_data;
                default:     cols_next     = cols_reg;
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.cell_glyph   = out_glyph_reg;
    assign rsp.cell_attr    = out_attr_reg;
    assign rsp.cursor_row   = out_row_reg;
    assign rsp.cursor_col   = out_col_reg;
    assign rsp.scroll_count = out_scroll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            cols_reg       <= COLS_RESET;
            rows_reg       <= ROWS_RESET;
            attr_cfg_reg   <= '0;
            clr_addr_reg   <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            clr_row_reg    <= '0;
            clr_col_reg    <= '0;
            puts_left_reg  <= '0;
            scroll_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cols_reg       <= cols_next;
            rows_reg       <= rows_next;
            attr_cfg_reg   <= attr_cfg_next;
            clr_addr_reg   <= clr_addr_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_reg        <= top_next;
            clr_row_reg    <= clr_row_next;
            clr_col_reg    <= clr_col_next;
            puts_left_reg  <= puts_left_next;
            scroll_cnt_reg <= scroll_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        res_glyph_reg  <= res_glyph_next;
        res_attr_reg   <= res_attr_next;
        out_glyph_reg  <= out_glyph_next;
        out_attr_reg   <= out_attr_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_scroll_reg <= out_scroll_next;
    end

    a_exec_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_EXEC |-> (top_w < nr) && (row_w < nr) && (col_w < nc))
        else $error("command executed with cursor or top offset outside the screen");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

    a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !pop && !out_load)
        else $error("command handled during the store clearing pass");

    a_scroll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_SCROLL && scroll_cnt_reg == '0 |=> 1'b0)
        else $error("scroll clear entered without counting the scroll");

    a_put_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_PUT |-> puts_left_reg != '0)
        else $error("cell write with no cells left to write");

endmodule

`default_nettype wire

@@ sv/text_terminal_screen_writer_top.sv @@
// Top level of the text terminal screen writer: front end, command queue and screen engine.
// A scroll clears one store line of MAX_COLS (128) cells. The screen engine writes one
// store cell per cycle through a single port; new transactions go into the command queue
// while it is busy with earlier ones, until the queue is full.
// Reset: rst_n is asynchronous and active low; afterwards the store is cleared one cell per
// cycle, during which no transaction is accepted (configuration writes are).
`default_nettype none

module text_terminal_screen_writer_top import ttsw_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    ttsw_req_if.sink                   req,
    ttsw_rsp_if.source                 rsp
);

    // The front end classifies each request transaction into a command, keeping the
    // escape filter state; it never needs the screen size or the cursor.
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      pop_cmd;
    q_status_t q_status;
    logic      clearing;

    ttsw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .req      (req),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // The queue lets new transactions be taken while the engine is busy scrolling
    // or waiting for the response side.
    ttsw_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // The engine owns the configuration registers, the cursor, the ring of screen rows
    // and the result register, which holds one response until it is taken.
    ttsw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .clearing  (clearing),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
